// File: src/kslp_pkg.sv
// ----------------------------------------------------------------------------
// kslp_pkg
// Shared types and constants of the key short/long press event detector.
// ----------------------------------------------------------------------------
package kslp_pkg;

   localparam int NUM_KEYS_DEFAULT = 2;

   localparam logic [31:0] DEBOUNCE_MS  = 32'd50;
   localparam logic [31:0] REPEAT_MS    = 32'd300;
   localparam logic [6:0]  LONG_UNIT_MS = 7'd100;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_LONG_PRESS_KEY0 = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY_ENABLE_MASK = 2'd2;

   typedef struct packed {
      logic [7:0] long_press_key0;
      logic [7:0] long_press_key1;
      logic [1:0] key_enable_mask;
   } cfg_type;

   typedef struct packed {
      logic [31:0] time_ms;
      logic        key_released;
      logic        key_index;
   } sample_type;

   typedef struct packed {
      logic [31:0] press_start_time;
      logic [31:0] last_long_time;
      logic [7:0]  press_counter;
   } key_state_type;

   typedef struct packed {
      logic       announce;
      logic       long_press;
      logic [7:0] press_count;
      logic       event_key;
   } result_type;

   function automatic logic [31:0] nonzero_time(input logic [31:0] t);
      return (t == 32'd0) ? 32'd1 : t;
   endfunction

endpackage

// File: src/key_short_long_press_events.sv
// ----------------------------------------------------------------------------
// key_short_long_press_events
// Short, long and repeat press event detector for up to two keys.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample of one key per transfer: the key index in
//   req_tuser, the pin level (1 released) and a millisecond timestamp in
//   req_tdata. rsp_* carries at most one event per sample: the key in
//   rsp_tuser, press count, long flag and announce flag in rsp_tdata.
//   csr_* writes the long-press thresholds (units of 100 ms) and the key
//   enable mask; write only while no sample is in flight.
// Timing:
//   A sample is held in the input register, is evaluated against the per-key
//   state, and its event is loaded into the result register once that register
//   can take it; rsp_tvalid comes straight from the result register. One
//   sample is taken every cycle while the result register is not stalled;
//   the per-key state is written as the sample leaves the input register, so
//   the next sample already sees it.
// Reset:
//   Clears both pipeline registers, all key state (idle, no long event, count
//   zero) and loads thresholds of 10 and an enable mask of both keys.
// Stall:
//   While rsp_tready is low with a result held, the input register holds;
//   req_tready stays high only until the input register is full.
// ----------------------------------------------------------------------------
module key_short_long_press_events #(
   parameter int NUM_KEYS = kslp_pkg::NUM_KEYS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] key_released, [32:1] time_ms, rest zero
   input  logic        req_tuser,   // [0] key_index
   // event channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] press_count, [8] long_press, [9] announce
   output logic        rsp_tuser,   // [0] event_key
   // configuration port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wr_data
);
   import kslp_pkg::*;

   cfg_type       cfg;

   logic          in_valid_ff;
   sample_type    in_sample_ff;
   logic          rsp_valid_ff;
   result_type    rsp_data_ff;

   key_state_type state_ff [NUM_KEYS];
   key_state_type cur_state;
   key_state_type nxt_state;

   logic          advance;
   logic          key_ok;
   logic          enabled;
   logic [7:0]    long_press_units;
   logic          hit;
   result_type    result;

   kslp_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // advance the evaluation stage whenever the result register can take it
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_sample_ff.key_index    <= req_tuser;
         in_sample_ff.key_released <= req_tdata[0];
         in_sample_ff.time_ms      <= req_tdata[32:1];
      end
   end

   // select the state and settings of the sampled key
   always_comb begin
      cur_state = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         if (1'(k) == in_sample_ff.key_index) begin
            cur_state = state_ff[k];
         end
      end
   end

   assign key_ok           = 32'(in_sample_ff.key_index) < 32'(NUM_KEYS);
   assign enabled          = key_ok && cfg.key_enable_mask[in_sample_ff.key_index];
   assign long_press_units = in_sample_ff.key_index ? cfg.long_press_key1
                                                    : cfg.long_press_key0;

   kslp_eval u_eval (
      .sample           (in_sample_ff),
      .cur              (cur_state),
      .enabled          (enabled),
      .long_press_units (long_press_units),
      .nxt              (nxt_state),
      .hit              (hit),
      .result           (result)
   );

   // write back the key state as the sample leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            state_ff[k] <= '0;
         end
      end else if (in_valid_ff && advance) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            if (1'(k) == in_sample_ff.key_index) begin
               state_ff[k] <= nxt_state;
            end
         end
      end
   end

   // result register: load a new event or drop the taken one
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && hit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && hit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.event_key;
   assign rsp_tdata  = {6'd0, rsp_data_ff.announce, rsp_data_ff.long_press,
                        rsp_data_ff.press_count};

`ifndef SYNTH
   // an event without announce can only be a repeat long event
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data_ff.announce |-> rsp_data_ff.long_press)
      else $error("short event without announce");

   // a stalled evaluation stage keeps its sample
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff))
      else $error("sample lost while result register stalled");

   // pipeline is empty the cycle after reset
   assert property (@(posedge clock)
      reset |=> !in_valid_ff && !rsp_valid_ff)
      else $error("pipeline not cleared by reset");

   // a locked key never yields an event
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && !enabled |=> !rsp_valid_ff)
      else $error("event from a locked key");
`endif

endmodule

// File: src/kslp_cfg.sv
// ----------------------------------------------------------------------------
// kslp_cfg
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module kslp_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wr_data,
   output kslp_pkg::cfg_type    cfg
);
   import kslp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LONG_PRESS_KEY0: cfg_in.long_press_key0 = csr_wr_data;
            CSR_LONG_PRESS_KEY1: cfg_in.long_press_key1 = csr_wr_data;
            CSR_KEY_ENABLE_MASK: cfg_in.key_enable_mask = csr_wr_data[1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_key0 <= 8'd10;
         cfg_ff.long_press_key1 <= 8'd10;
         cfg_ff.key_enable_mask <= 2'b11;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/kslp_eval.sv
// ----------------------------------------------------------------------------
// kslp_eval
// Press decision for one sample against the stored state of its key.
// ----------------------------------------------------------------------------
module kslp_eval (
   input  kslp_pkg::sample_type    sample,
   input  kslp_pkg::key_state_type cur,
   input  logic                    enabled,
   input  logic [7:0]              long_press_units,
   output kslp_pkg::key_state_type nxt,
   output logic                    hit,
   output kslp_pkg::result_type    result
);
   import kslp_pkg::*;

   logic [31:0] since_press;
   logic [31:0] since_long;
   logic [14:0] threshold;

   assign since_press = sample.time_ms - cur.press_start_time;
   assign since_long  = sample.time_ms - cur.last_long_time;
   assign threshold   = long_press_units * LONG_UNIT_MS;

   always_comb begin
      nxt                = cur;
      hit                = 1'b0;
      result.event_key   = sample.key_index;
      result.long_press  = 1'b0;
      result.announce    = 1'b0;
      if (enabled) begin
         if (sample.key_released) begin
            if (cur.press_start_time != 32'd0) begin
               nxt.press_start_time = 32'd0;
               // short event only when debounced and no long event was sent
               if (since_press >= DEBOUNCE_MS && cur.last_long_time == 32'd0) begin
                  nxt.press_counter = cur.press_counter + 8'd1;
                  hit               = 1'b1;
                  result.announce   = 1'b1;
               end
            end
         end else if (cur.press_start_time == 32'd0) begin
            nxt.press_start_time = nonzero_time(sample.time_ms);
            nxt.last_long_time   = 32'd0;
         end else if (cur.last_long_time != 32'd0) begin
            if (since_long >= REPEAT_MS) begin
               nxt.last_long_time = nonzero_time(sample.time_ms);
               hit                = 1'b1;
               result.long_press  = 1'b1;
            end
         end else if (since_press >= {17'd0, threshold}) begin
            // first long event keeps the timestamp as is, zero included
            nxt.press_counter  = cur.press_counter + 8'd1;
            nxt.last_long_time = sample.time_ms;
            hit                = 1'b1;
            result.long_press  = 1'b1;
            result.announce    = 1'b1;
         end
      end
      result.press_count = nxt.press_counter;
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key short/long press event detector.
// ----------------------------------------------------------------------------
// Key samples go in on the req_ stream. A behavioral model of the per-key
// press state predicts the event, if any, that each accepted sample causes.
// Events coming out on the rsp_ stream are checked in order against those
// predictions. Directed tests cover debounce, long and repeat timing, timer
// wrap, the zero-timestamp cases, threshold extremes, key locking and counter
// wrap. Random phases follow, each with its own thresholds, enable mask and
// idle/stall pattern on both streams.
// ----------------------------------------------------------------------------
module tb;
   import kslp_pkg::*;

   localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer before giving up
   localparam int PHASE_SAMPLES = 100;   // evaluated samples per random phase

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;   // [0] key_released, [32:1] time_ms, rest zero
   logic        req_tuser   = 1'b0; // [0] key_index
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] press_count, [8] long_press, [9] announce
   logic        rsp_tuser;          // [0] event_key
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_index   = '0;
   logic [7:0]  csr_wr_data = '0;

   // model of the block: configuration and per-key press state
   cfg_type     model_cfg = '{long_press_key0: 8'd10, long_press_key1: 8'd10,
                              key_enable_mask: 2'b11};
   logic [31:0] press_start_ms [2] = '{32'd0, 32'd0};
   logic [31:0] last_long_ms   [2] = '{32'd0, 32'd0};
   logic [7:0]  press_count    [2] = '{8'd0, 8'd0};

   result_type  expected_events[$];
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;

   // random sample generator: last level and timestamp sent per key
   logic [31:0] gen_ms   [2] = '{32'd0, 32'd0};
   logic        gen_down [2] = '{1'b0, 1'b0};

   key_short_long_press_events dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Advance the press state of one key by one sample; return 1 and the event
   // when the sample causes one.
   function automatic bit predict_event(input logic key, input logic released,
                                        input logic [31:0] now,
                                        output result_type ev);
      logic [31:0] hold_limit;
      bit          fire;
      ev = '0;
      ev.event_key = key;
      // locked key: nothing changes
      if (!model_cfg.key_enable_mask[key]) return 0;

      if (released) begin
         if (press_start_ms[key] == 32'd0) return 0;
         // a release after a long event or inside the debounce window is silent
         fire = (now - press_start_ms[key] >= DEBOUNCE_MS) && (last_long_ms[key] == 32'd0);
         press_start_ms[key] = 32'd0;
         if (!fire) return 0;
         press_count[key] = press_count[key] + 8'd1;
         ev.press_count = press_count[key];
         ev.announce    = 1'b1;
         return 1;
      end

      // new press: a start at time zero is kept as 1 so the key does not look idle
      if (press_start_ms[key] == 32'd0) begin
         press_start_ms[key] = (now == 32'd0) ? 32'd1 : now;
         last_long_ms[key]   = 32'd0;
         return 0;
      end

      // held after a long event: repeat every REPEAT_MS, no count, no announce
      if (last_long_ms[key] != 32'd0) begin
         if (now - last_long_ms[key] < REPEAT_MS) return 0;
         last_long_ms[key] = (now == 32'd0) ? 32'd1 : now;
         ev.press_count = press_count[key];
         ev.long_press  = 1'b1;
         return 1;
      end

      hold_limit = (key == 1'b0) ? model_cfg.long_press_key0 : model_cfg.long_press_key1;
      hold_limit = hold_limit * LONG_UNIT_MS;
      if (now - press_start_ms[key] < hold_limit) return 0;
      // first long event keeps the timestamp as is, even zero
      press_count[key]  = press_count[key] + 8'd1;
      last_long_ms[key] = now;
      ev.press_count = press_count[key];
      ev.long_press  = 1'b1;
      ev.announce    = 1'b1;
      return 1;
   endfunction

   task automatic flag_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // Send one key sample, with an optional idle gap first; predict on transfer.
   task automatic send_sample(input logic key, input logic released, input logic [31:0] ms);
      result_type ev;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, ms, released};
      req_tuser  <= key;
      do @(posedge clock); while (!req_tready);
      if (predict_event(key, released, ms, ev)) expected_events.push_back(ev);
   endtask

   // Drop valid and let the pipeline run dry before touching the registers.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_LONG_PRESS_KEY0: model_cfg.long_press_key0 = value;
         CSR_LONG_PRESS_KEY1: model_cfg.long_press_key1 = value;
         CSR_KEY_ENABLE_MASK: model_cfg.key_enable_mask = value[1:0];
         default: ;
      endcase
   endtask

   // Debounce window, timestamp wrap between press and release, release while idle.
   task automatic test_short_press();
      send_sample(1'b0, 1'b0, 32'd0);            // start stored as 1
      send_sample(1'b0, 1'b1, 32'd49);           // 48 ms: too short
      send_sample(1'b0, 1'b0, 32'd2000);
      send_sample(1'b0, 1'b1, 32'd2050);         // exactly 50 ms: short event
      send_sample(1'b1, 1'b0, 32'hFFFF_FFF0);
      send_sample(1'b1, 1'b1, 32'h0000_0022);    // 50 ms across the wrap
      send_sample(1'b1, 1'b1, 32'd123);          // release while idle
   endtask

   // Long event at the threshold, repeats, and the zero-timestamp cases.
   task automatic test_long_and_repeat();
      send_sample(1'b0, 1'b0, 32'd10000);
      send_sample(1'b0, 1'b0, 32'd10999);        // one short of 1000 ms
      send_sample(1'b0, 1'b0, 32'd11000);        // first long
      send_sample(1'b0, 1'b0, 32'd11299);
      send_sample(1'b0, 1'b0, 32'd11300);        // repeat
      send_sample(1'b0, 1'b1, 32'd11400);        // release after long: silent
      // first long at time zero stays zero: every held sample is a new first long,
      // and the release then still counts as a short press
      send_sample(1'b1, 1'b0, 32'hFFFF_FC18);
      send_sample(1'b1, 1'b0, 32'd0);
      send_sample(1'b1, 1'b0, 32'd5);
      send_sample(1'b1, 1'b1, 32'd60);
      // repeat at time zero is stored as 1
      send_sample(1'b0, 1'b0, 32'hFFFF_F830);
      send_sample(1'b0, 1'b0, 32'hFFFF_FC18);    // first long
      send_sample(1'b0, 1'b0, 32'd0);            // repeat, stored as 1
      send_sample(1'b0, 1'b0, 32'd300);          // 299 ms since: nothing
      send_sample(1'b0, 1'b0, 32'd301);          // repeat
      send_sample(1'b0, 1'b1, 32'd400);
      // press at zero held at zero: the stored 1 makes the hold look huge
      send_sample(1'b0, 1'b0, 32'd0);
      send_sample(1'b0, 1'b0, 32'd0);
      send_sample(1'b0, 1'b1, 32'd10);
   endtask

   // Threshold extremes on both keys.
   task automatic test_thresholds();
      settle();
      csr_write(CSR_LONG_PRESS_KEY0, 8'd0);
      csr_write(CSR_LONG_PRESS_KEY1, 8'd255);
      send_sample(1'b0, 1'b0, 32'd500);
      send_sample(1'b0, 1'b0, 32'd500);          // zero threshold: long at once
      send_sample(1'b1, 1'b0, 32'd100);
      send_sample(1'b1, 1'b0, 32'd25599);        // 25499 ms: not yet
      send_sample(1'b1, 1'b0, 32'd25600);        // 25500 ms: long
      send_sample(1'b0, 1'b1, 32'd600);
      send_sample(1'b1, 1'b1, 32'd25700);
      settle();
      csr_write(CSR_LONG_PRESS_KEY0, 8'd255);
      csr_write(CSR_LONG_PRESS_KEY1, 8'd0);
      send_sample(1'b1, 1'b0, 32'd7);
      send_sample(1'b1, 1'b0, 32'd7);
      send_sample(1'b1, 1'b1, 32'd8);
      send_sample(1'b0, 1'b0, 32'd1000);
      send_sample(1'b0, 1'b1, 32'd1200);         // short: threshold is far away
      settle();
      csr_write(CSR_LONG_PRESS_KEY0, 8'd10);
      csr_write(CSR_LONG_PRESS_KEY1, 8'd10);
   endtask

   // Locked keys ignore samples and keep their state; upper mask bits are dropped.
   task automatic test_key_lock();
      send_sample(1'b1, 1'b0, 32'd1000);         // key 1 held before locking
      settle();
      csr_write(CSR_KEY_ENABLE_MASK, 8'hFD);     // key 0 only
      send_sample(1'b1, 1'b1, 32'd2000);         // ignored
      send_sample(1'b0, 1'b0, 32'd3000);
      send_sample(1'b0, 1'b1, 32'd3100);
      settle();
      csr_write(CSR_KEY_ENABLE_MASK, 8'h02);     // key 1 only
      send_sample(1'b0, 1'b0, 32'd4000);         // ignored
      send_sample(1'b1, 1'b1, 32'd4100);         // short, from the press at 1000
      settle();
      csr_write(CSR_KEY_ENABLE_MASK, 8'h00);
      send_sample(1'b0, 1'b0, 32'd5000);
      send_sample(1'b1, 1'b0, 32'd5000);
      settle();
      csr_write(CSR_KEY_ENABLE_MASK, 8'h03);
   endtask

   // Push both press counters past 255.
   task automatic test_counter_wrap();
      logic [31:0] ms;
      send_idle_pct = 28;
      stall_pct     = 28;
      ms = $urandom();
      for (int i = 0; i < 520; i++) begin
         send_sample(1'(i), 1'b0, ms);
         send_sample(1'(i), 1'b1, ms + 32'd50 + $urandom_range(0, 100));
         ms = ms + 32'd1000;
      end
   endtask

   // Mostly plausible press/hold/release traffic per key, with some noise.
   task automatic send_random_sample(output bit evaluated);
      logic        key;
      logic        released;
      logic [31:0] ms;
      key = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 12) begin
         ms       = $urandom();
         released = 1'($urandom_range(0, 1));
      end else begin
         case ($urandom_range(0, 3))
            0: ms = gen_ms[key] + $urandom_range(0, 60);
            1: ms = gen_ms[key] + $urandom_range(280, 320);
            2: ms = gen_ms[key] + $urandom_range(0, 600);
            default: ms = gen_ms[key] + $urandom_range(0, 1200);
         endcase
         released = gen_down[key] && ($urandom_range(0, 99) < 30);
      end
      if ($urandom_range(0, 199) == 0) ms = 32'd0;
      evaluated = model_cfg.key_enable_mask[key];
      send_sample(key, released, ms);
      gen_ms[key]   = ms;
      gen_down[key] = !released;
   endtask

   task automatic pick_random_config();
      logic [7:0] limit [2];
      logic [1:0] mask;
      for (int k = 0; k < 2; k++) begin
         case ($urandom_range(0, 19))
            0: limit[k] = 8'd0;
            1: limit[k] = 8'd255;
            default: limit[k] = 8'($urandom_range(1, 5));
         endcase
      end
      mask = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 2)) : 2'b11;
      settle();
      csr_write(CSR_LONG_PRESS_KEY0, limit[0]);
      csr_write(CSR_LONG_PRESS_KEY1, limit[1]);
      csr_write(CSR_KEY_ENABLE_MASK, {6'($urandom_range(0, 63)), mask});
   endtask

   task automatic test_random_phases();
      bit evaluated;
      int sent;
      for (int phase = 0; phase < 4; phase++) begin
         pick_random_config();
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         gen_ms[0] = $urandom();
         gen_ms[1] = $urandom();
         sent = 0;
         while (sent < PHASE_SAMPLES) begin
            send_random_sample(evaluated);
            if (evaluated) sent++;
         end
      end
   endtask

   // Event checker and receiver stalls.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            flag_failure($sformatf("unexpected event: key %0d count %0d long %0d announce %0d",
                                   rsp_tuser, rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9]));
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.event_key || rsp_tdata[7:0] !== want.press_count ||
                rsp_tdata[8] !== want.long_press || rsp_tdata[9] !== want.announce) begin
               flag_failure($sformatf({"event mismatch: expected key %0d count %0d long %0d ",
                                       "announce %0d, got key %0d count %0d long %0d ",
                                       "announce %0d"},
                                      want.event_key, want.press_count, want.long_press,
                                      want.announce, rsp_tuser, rsp_tdata[7:0],
                                      rsp_tdata[8], rsp_tdata[9]));
            end
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Watchdog: advance on cycles without any transfer, clear on a transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
         $display("[key_short_long_press_events] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_press();
      test_long_and_repeat();
      test_thresholds();
      test_key_lock();
      test_counter_wrap();
      test_random_phases();

      // drain: everything predicted must have arrived
      settle();
      repeat (10) @(posedge clock);
      if (expected_events.size() != 0) begin
         flag_failure($sformatf("%0d expected events never arrived", expected_events.size()));
      end
      if (mismatch_count == 0) begin
         $display("[key_short_long_press_events] OK");
      end else begin
         $display("[key_short_long_press_events] ERROR");
      end
      $finish;
   end

endmodule
